>>> rtl/sobel_gradient_3x3_assert.svh
// Assertion shorthands used by sobel_gradient_3x3.sv. Each expects clk and rst_n in scope.
`ifndef SOBEL_GRADIENT_3X3_ASSERT_SVH
`define SOBEL_GRADIENT_3X3_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define SG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define SG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/sg_pkg.sv
`default_nettype none

package sg_pkg;

  // Pixel and result widths
  localparam int PIX_W  = 12;
  localparam int SUM_W  = 14;  // t + 2m + b, unsigned
  localparam int DIFF_W = 13;  // b - t, signed
  localparam int GRAD_W = 15;

  // Line length and frame height limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int EFFW_W     = COL_W + 1;
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int EFFH_W     = ROW_W + 1;
  localparam int MIN_SIZE   = 3;
  localparam int WIN_EDGE   = 2;  // first column / row with a full window

  // Configuration registers
  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 2;
  localparam int CMPW_W = (CFG_WIDTH_W > EFFW_W) ? CFG_WIDTH_W : EFFW_W;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RST  = 11'd640;
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RST = 13'd480;

  // One window column, top to bottom
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } col_t;

endpackage

`default_nettype wire

>>> rtl/sg_ram.sv
`default_nettype none

module sg_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Simple dual port, registered read; a same-address read returns the old word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/sg_cell.sv
`default_nettype none

module sg_cell (
  input  wire logic                            clk,
  input  wire logic                            en,
  input  wire sg_pkg::col_t                    col_in,
  output sg_pkg::col_t                         col_out,
  output logic        [sg_pkg::SUM_W-1:0]      smooth,
  output logic signed [sg_pkg::DIFF_W-1:0]     diff
);

  sg_pkg::col_t                       col_r;
  logic        [sg_pkg::SUM_W-1:0]    smooth_r;
  logic        [sg_pkg::SUM_W-1:0]    smooth_nxt;
  logic signed [sg_pkg::DIFF_W-1:0]   diff_r;
  logic signed [sg_pkg::DIFF_W-1:0]   diff_nxt;

  // Vertical smoothing (1,2,1) and vertical difference of the incoming column
  always_comb begin
    smooth_nxt = sg_pkg::SUM_W'(col_in.top)
               + {1'b0, col_in.mid, 1'b0}
               + sg_pkg::SUM_W'(col_in.bot);
    diff_nxt   = $signed({1'b0, col_in.bot}) - $signed({1'b0, col_in.top});
  end

  // Column moves one cell left on every window shift
  always_ff @(posedge clk) begin
    if (en) begin
      col_r    <= col_in;
      smooth_r <= smooth_nxt;
      diff_r   <= diff_nxt;
    end
  end

  assign col_out = col_r;
  assign smooth  = smooth_r;
  assign diff    = diff_r;

endmodule

`default_nettype wire

>>> rtl/sobel_gradient_3x3.sv
// 3x3 Sobel gradient over a raster stream of 12-bit grey pixels. One pixel is taken
// per clock for as long as out_stall stays low; a registered result follows the
// pixel that completes its window, at the window centre (one row up, one column
// left). The rate is set by the two line stores, each a simple dual-port RAM read
// when a pixel is taken and written on commit, with a one-entry bypass for
// back-to-back hits on the same column. Only interior pixels give a result;
// out_frame_end flags the last one of a frame. in_frame_start restarts the row and
// column count. image_width (clamped to 3..1024) and image_height (clamped to
// 3..4096) must be written over cfg_* only while the block is idle (not enforced).
// Line store contents are not cleared at reset; there is no clearing pass.
`default_nettype none
`include "sobel_gradient_3x3_assert.svh"

module sobel_gradient_3x3 (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // configuration
  input  wire logic                               cfg_we,
  input  wire logic [sg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [sg_pkg::CFG_DATA_W-1:0]      cfg_data,
  // pixel items in
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [sg_pkg::PIX_W-1:0]           in_pixel,
  input  wire logic                               in_frame_start,
  // gradient items out
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [sg_pkg::GRAD_W-1:0]        out_grad_x,
  output logic signed [sg_pkg::GRAD_W-1:0]        out_grad_y,
  output logic                                    out_frame_end
);

  // Configuration
  logic [sg_pkg::CFG_WIDTH_W-1:0]  width_r;
  logic [sg_pkg::CFG_HEIGHT_W-1:0] height_r;
  logic [sg_pkg::CMPW_W-1:0]       wide_w;
  logic [sg_pkg::EFFW_W-1:0]       eff_w;
  logic [sg_pkg::EFFH_W-1:0]       eff_h;

  // Position counters
  logic [sg_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [sg_pkg::ROW_W-1:0]  row_r, row_nxt;
  logic [sg_pkg::COL_W-1:0]  c0, c1;
  logic [sg_pkg::ROW_W-1:0]  r0, rr;
  logic [sg_pkg::EFFH_W-1:0] r1, r_inc;
  logic [sg_pkg::EFFW_W-1:0] c_inc;
  logic                      interior, last;

  // Handshake and pipeline control
  logic accept, commit, ld_out, s2_free, s1_free;

  // Line store read stage
  logic                       v1_r;
  logic [sg_pkg::PIX_W-1:0]   pix1_r;
  logic [sg_pkg::COL_W-1:0]   col1_r;
  logic                       interior1_r, last1_r;
  logic                       byp_r, byp_nxt;
  logic [sg_pkg::PIX_W-1:0]   fwd_up_r, fwd_mid_r;
  logic [sg_pkg::PIX_W-1:0]   up_rd, mid_rd, up_val, mid_val;

  // Window stage
  logic                       v2_r, last2_r;
  sg_pkg::col_t               new_col;
  sg_pkg::col_t               cell_col [3];
  logic        [sg_pkg::SUM_W-1:0]  cell_smooth [3];
  logic signed [sg_pkg::DIFF_W-1:0] cell_diff [3];

  // Output register
  logic                              out_valid_r, out_valid_nxt;
  logic signed [sg_pkg::GRAD_W-1:0]  gx_r, gx_nxt, gy_r, gy_nxt;
  logic                              frame_end_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= sg_pkg::WIDTH_RST;
      height_r <= sg_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sg_pkg::CFG_IMAGE_WIDTH:  width_r  <= cfg_data[sg_pkg::CFG_WIDTH_W-1:0];
        sg_pkg::CFG_IMAGE_HEIGHT: height_r <= cfg_data[sg_pkg::CFG_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the frame size into range
  always_comb begin
    wide_w = sg_pkg::CMPW_W'(width_r);
    if (wide_w < sg_pkg::CMPW_W'(sg_pkg::MIN_SIZE)) begin
      eff_w = sg_pkg::EFFW_W'(sg_pkg::MIN_SIZE);
    end else if (wide_w > sg_pkg::CMPW_W'(sg_pkg::MAX_WIDTH)) begin
      eff_w = sg_pkg::EFFW_W'(sg_pkg::MAX_WIDTH);
    end else begin
      eff_w = sg_pkg::EFFW_W'(wide_w);
    end
    if (height_r < sg_pkg::CFG_HEIGHT_W'(sg_pkg::MIN_SIZE)) begin
      eff_h = sg_pkg::EFFH_W'(sg_pkg::MIN_SIZE);
    end else if (height_r > sg_pkg::CFG_HEIGHT_W'(sg_pkg::MAX_HEIGHT)) begin
      eff_h = sg_pkg::EFFH_W'(sg_pkg::MAX_HEIGHT);
    end else begin
      eff_h = sg_pkg::EFFH_W'(height_r);
    end
  end

  // Position of the incoming pixel and of the one after it
  always_comb begin
    c0 = in_frame_start ? '0 : col_r;
    r0 = in_frame_start ? '0 : row_r;
    // column left over from a larger width starts the next row
    if ({1'b0, c0} >= eff_w) begin
      c1 = '0;
      r1 = {1'b0, r0} + 1'b1;
    end else begin
      c1 = c0;
      r1 = {1'b0, r0};
    end
    rr    = (r1 >= eff_h) ? '0 : r1[sg_pkg::ROW_W-1:0];
    c_inc = {1'b0, c1} + 1'b1;
    r_inc = {1'b0, rr} + 1'b1;
    if (c_inc >= eff_w) begin
      col_nxt = '0;
      row_nxt = (r_inc >= eff_h) ? '0 : r_inc[sg_pkg::ROW_W-1:0];
    end else begin
      col_nxt = c_inc[sg_pkg::COL_W-1:0];
      row_nxt = rr;
    end
    interior = (rr >= sg_pkg::ROW_W'(sg_pkg::WIN_EDGE))
            && (c1 >= sg_pkg::COL_W'(sg_pkg::WIN_EDGE));
    last     = (r_inc == eff_h) && (c_inc == eff_w);
  end

  // Flow control: each stage moves when the one after it has room
  always_comb begin
    ld_out   = v2_r && (!out_valid_r || !out_stall);
    s2_free  = !v2_r || ld_out;
    commit   = v1_r && s2_free;
    s1_free  = !v1_r || commit;
    in_stall = !s1_free;
    accept   = in_valid && s1_free;
    byp_nxt  = commit && (col1_r == c1);
    out_valid_nxt = ld_out || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (accept) begin
        v1_r <= 1'b1;
      end else if (commit) begin
        v1_r <= 1'b0;
      end
      if (commit) begin
        v2_r <= interior1_r;
      end else if (ld_out) begin
        v2_r <= 1'b0;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // Read stage payload, with bypass of the word being written this cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      pix1_r      <= in_pixel;
      col1_r      <= c1;
      interior1_r <= interior;
      last1_r     <= last;
      byp_r       <= byp_nxt;
      fwd_up_r    <= mid_val;
      fwd_mid_r   <= pix1_r;
    end
    if (commit) begin
      last2_r <= last1_r;
    end
  end

  assign up_val  = byp_r ? fwd_up_r  : up_rd;
  assign mid_val = byp_r ? fwd_mid_r : mid_rd;

  // Line stores: two rows up and one row up
  sg_ram #(.WIDTH(sg_pkg::PIX_W), .DEPTH(sg_pkg::MAX_WIDTH)) u_line_upper (
    .clk     (clk),
    .wr_en   (commit),
    .wr_addr (col1_r),
    .wr_data (mid_val),
    .rd_en   (accept),
    .rd_addr (c1),
    .rd_data (up_rd)
  );

  sg_ram #(.WIDTH(sg_pkg::PIX_W), .DEPTH(sg_pkg::MAX_WIDTH)) u_line_middle (
    .clk     (clk),
    .wr_en   (commit),
    .wr_addr (col1_r),
    .wr_data (pix1_r),
    .rd_en   (accept),
    .rd_addr (c1),
    .rd_data (mid_rd)
  );

  // Window: three column cells, new column enters on the right
  always_comb begin
    new_col.top = up_val;
    new_col.mid = mid_val;
    new_col.bot = pix1_r;
  end

  sg_cell u_cell_right (
    .clk     (clk),
    .en      (commit),
    .col_in  (new_col),
    .col_out (cell_col[2]),
    .smooth  (cell_smooth[2]),
    .diff    (cell_diff[2])
  );

  sg_cell u_cell_centre (
    .clk     (clk),
    .en      (commit),
    .col_in  (cell_col[2]),
    .col_out (cell_col[1]),
    .smooth  (cell_smooth[1]),
    .diff    (cell_diff[1])
  );

  sg_cell u_cell_left (
    .clk     (clk),
    .en      (commit),
    .col_in  (cell_col[1]),
    .col_out (cell_col[0]),
    .smooth  (cell_smooth[0]),
    .diff    (cell_diff[0])
  );

  // Gradients from the per-column terms
  always_comb begin
    gx_nxt = $signed({1'b0, cell_smooth[2]}) - $signed({1'b0, cell_smooth[0]});
    gy_nxt = sg_pkg::GRAD_W'(cell_diff[0])
           + (sg_pkg::GRAD_W'(cell_diff[1]) <<< 1)
           + sg_pkg::GRAD_W'(cell_diff[2]);
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      gx_r        <= gx_nxt;
      gy_r        <= gy_nxt;
      frame_end_r <= last2_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_grad_x    = gx_r;
  assign out_grad_y    = gy_r;
  assign out_frame_end = frame_end_r;

  // Checks
  `SG_ASSERT_NEXT(a_col_in_range, accept, col_r < $past(eff_w),
    "column count not below width after an item")
  `SG_ASSERT_NEXT(a_row_in_range, accept, {1'b0, row_r} < $past(eff_h),
    "row count not below height after an item")
  `SG_ASSERT_NOW(a_empty_takes, !v1_r, !in_stall,
    "input stalled with the read stage empty")
  `SG_ASSERT_NEXT(a_window_holds, v2_r && !ld_out, v2_r && $stable(cell_col[2]),
    "window shifted under a waiting result")

endmodule

`default_nettype wire
